@@ src/assert_macros.svh @@
// Assertion macros shared by the texture tile swizzle address RTL.
// Needs a clock named clk and an active-low asynchronous reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication: whenever ante holds, cons must follow.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

`endif

@@ src/tts_pkg.sv @@
// Shared types and constants for the texture tile swizzle address block.
// No dependencies; used by tts_rem_stage and texture_tile_swizzle_address_core.
package tts_pkg;

	localparam int COORD_W = 10;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;
	localparam int LUT_W = 20;
	localparam int LOOKUP_W = 8;
	localparam int PIX_S_W = 3;
	localparam int ROW_W = 3;

	localparam int MAX_DIM_DEF = 1024;
	localparam int TEX_WIDTH_RST = 1024;

	// Number of pipeline stages that work out the tile column remainder.
	localparam int NUM_DIV = 4;

	localparam logic [LOOKUP_W-1:0] PIX_T_BIAS = 8'd128;

	localparam logic [CFG_IDX_W-1:0] CFG_TILE_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH = 1'b1;

	typedef enum logic [1:0] {
		TILE_8X8 = 2'd0,
		TILE_8X4 = 2'd1,
		TILE_4X4 = 2'd2
	} tile_mode_t;

	// Result fields that ride along the remainder pipeline.
	typedef struct packed {
		logic [LUT_W-1:0] lut_index;
		logic [LOOKUP_W-1:0] tile_t;
		logic [PIX_S_W-1:0] pix_s;
		logic [LOOKUP_W-1:0] pix_t;
	} side_t;

endpackage

@@ src/tts_rem_stage.sv @@
// One stage of the pipelined restoring remainder used for the tile column.
// Depends on tts_pkg for the side-band result struct.
module tts_rem_stage #(
	parameter int QP_W = 16,
	parameter int STEPS = 4,
	parameter int R_W = 9
) (
	input  logic clk,
	input  logic arst_n,
	input  logic valid_in,
	input  logic [QP_W-1:0] q_in,
	input  logic [R_W-1:0] rem_in,
	input  logic [R_W-1:0] div_in,
	input  tts_pkg::side_t side_in,
	output logic valid_s,
	output logic [QP_W-1:0] q_s,
	output logic [R_W-1:0] rem_s,
	output logic [R_W-1:0] div_s,
	output tts_pkg::side_t side_s
);

	logic [QP_W-1:0] q_d;
	logic [R_W-1:0] rem_d;

	// Each step brings down the next dividend bit and subtracts the divisor if it fits.
	always_comb begin
		logic [R_W:0] t;
		logic [R_W-1:0] r;
		logic [QP_W-1:0] q;
		r = rem_in;
		q = q_in;
		for (int i = 0; i < STEPS; i++) begin
			t = {r, q[QP_W-1]};
			q = q << 1;
			if (t >= {1'b0, div_in}) begin
				r = R_W'(t - {1'b0, div_in});
			end else begin
				r = t[R_W-1:0];
			end
		end
		rem_d = r;
		q_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else begin
			valid_s <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		q_s <= q_d;
		rem_s <= rem_d;
		div_s <= div_in;
		side_s <= side_in;
	end

endmodule

@@ src/texture_tile_swizzle_address_core.sv @@
// Top level of the texture tile swizzle address generator.
// Depends on tts_pkg, tts_rem_stage and assert_macros.svh.

// The block takes one texel coordinate per clock cycle and returns, for every
// accepted transaction, the 4x4-block swizzled lookup index, the tile lookup
// entry (tile_s, tile_t) and the pixel lookup entry (pix_s, pix_t). A transaction
// is accepted on any clock edge where start is high; busy is always low because
// the pipeline never stalls, and the receiver cannot hold results off either.
// Each result appears on the result ports for exactly one cycle, marked by done,
// once its transaction has passed stage 1 and every remainder stage.
// The first stage forms the linear texel number y*width+x and the swizzled
// index with one multiplier each; the following stages reduce the tile number
// modulo the tiles per row, STEPS bits per stage, which sets the latency.
// Sustained throughput is one transaction per cycle. There is no clearing pass
// after reset. Configuration (tile_mode at index 0, texture_width at index 1)
// must only be written while no transaction is in flight; a width of zero acts
// as one, a width above MAX_DIM acts as MAX_DIM, and tile mode 3 acts as 4x4.
module texture_tile_swizzle_address_core #(
	parameter int MAX_DIM = tts_pkg::MAX_DIM_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tts_pkg::CFG_W-1:0] cfg_wdata,
	input  logic [tts_pkg::COORD_W-1:0] x_coord,
	input  logic [tts_pkg::COORD_W-1:0] y_coord,
	output logic done,
	output logic [tts_pkg::LUT_W-1:0] lut_index,
	output logic [tts_pkg::LOOKUP_W-1:0] tile_s,
	output logic [tts_pkg::LOOKUP_W-1:0] tile_t,
	output logic [tts_pkg::PIX_S_W-1:0] pix_s,
	output logic [tts_pkg::LOOKUP_W-1:0] pix_t
);

`include "assert_macros.svh"

	localparam int COORD_W = tts_pkg::COORD_W;
	localparam int CFG_W = tts_pkg::CFG_W;
	localparam int NUM_DIV = tts_pkg::NUM_DIV;
	localparam int LAT = NUM_DIV + 1;
	// Effective texture width, 1 .. MAX_DIM.
	localparam int W_W = $clog2(MAX_DIM + 1);
	// Blocks (and tiles) per row never exceed ceil(MAX_DIM / 4).
	localparam int BX_MAX = (MAX_DIM + 3) / 4;
	localparam int BX_W = $clog2(BX_MAX + 1);
	// Largest linear texel number is (2^COORD_W - 1) * MAX_DIM + 2^COORD_W - 1.
	localparam int LIN_W = $clog2((2 ** COORD_W - 1) * MAX_DIM + 2 ** COORD_W);
	// Smallest tile holds 16 texels, so the tile number drops at least four bits.
	localparam int Q_W = LIN_W - 4;
	localparam int STEPS = (Q_W + NUM_DIV - 1) / NUM_DIV;
	localparam int QP_W = STEPS * NUM_DIV;
	localparam int BLK_MAX = (2 ** COORD_W) / 4;
	localparam int LS_W = $clog2((BLK_MAX - 1) * BX_MAX + BLK_MAX);

	function automatic logic [W_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		logic [W_W-1:0] w;
		if (v == '0) begin
			w = W_W'(1);
		end else if (v > CFG_W'(MAX_DIM)) begin
			w = W_W'(MAX_DIM);
		end else begin
			w = W_W'(v);
		end
		return w;
	endfunction

	function automatic logic [BX_W-1:0] blocks_per_row(input logic [W_W-1:0] w);
		logic [W_W+1:0] sum;
		sum = {2'b00, w} + (W_W + 2)'(3);
		return BX_W'(sum >> 2);
	endfunction

	function automatic logic [BX_W-1:0] tiles_per_row(input tts_pkg::tile_mode_t m,
			input logic [W_W-1:0] w);
		logic [W_W+1:0] sum;
		logic [BX_W-1:0] n;
		case (m)
			tts_pkg::TILE_8X8, tts_pkg::TILE_8X4: begin
				sum = {2'b00, w} + (W_W + 2)'(7);
				n = BX_W'(sum >> 3);
			end
			default: begin
				n = blocks_per_row(w);
			end
		endcase
		return n;
	endfunction

	// Configuration registers, kept in their effective form.
	tts_pkg::tile_mode_t mode_q;
	logic [W_W-1:0] w_eff_q;
	logic [BX_W-1:0] bx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tts_pkg::TILE_8X8;
			w_eff_q <= clamp_width(CFG_W'(tts_pkg::TEX_WIDTH_RST));
			bx_q <= blocks_per_row(clamp_width(CFG_W'(tts_pkg::TEX_WIDTH_RST)));
		end else if (cfg_we) begin
			case (cfg_index)
				tts_pkg::CFG_TILE_MODE: begin
					mode_q <= tts_pkg::tile_mode_t'(cfg_wdata[1:0]);
				end
				tts_pkg::CFG_TEX_WIDTH: begin
					w_eff_q <= clamp_width(cfg_wdata);
					bx_q <= blocks_per_row(clamp_width(cfg_wdata));
				end
				default: begin
				end
			endcase
		end
	end

	// The pipeline never stalls, so a new transaction is welcome every cycle.
	assign busy = 1'b0;

	// Stage 1: linear texel number, swizzled index and the shape-only fields.
	logic valid_s1;
	logic [LIN_W-1:0] lin_s1;
	logic [tts_pkg::LUT_W-1:0] lut_s1;
	logic [tts_pkg::LOOKUP_W-1:0] tile_t_s1;
	logic [tts_pkg::PIX_S_W-1:0] pix_s_s1;
	logic [tts_pkg::LOOKUP_W-1:0] y_s1;
	tts_pkg::tile_mode_t mode_s1;
	logic [BX_W-1:0] tpr_s1;

	logic [LS_W-1:0] blk_sum;
	logic [LS_W+3:0] lut_full;
	logic [tts_pkg::LOOKUP_W-1:0] tile_t_d;
	logic [tts_pkg::PIX_S_W-1:0] pix_s_d;

	// Index of the 4x4 block, then the texel's place inside it in the low four bits.
	assign blk_sum = LS_W'(LS_W'(y_coord[COORD_W-1:2]) * LS_W'(bx_q)
		+ LS_W'(x_coord[COORD_W-1:2]));
	assign lut_full = {blk_sum, y_coord[1:0], x_coord[1:0]};

	always_comb begin
		case (mode_q)
			tts_pkg::TILE_8X8: begin
				tile_t_d = tts_pkg::LOOKUP_W'(y_coord >> 3);
				pix_s_d = x_coord[2:0];
			end
			tts_pkg::TILE_8X4: begin
				tile_t_d = tts_pkg::LOOKUP_W'(y_coord >> 2);
				pix_s_d = x_coord[2:0];
			end
			default: begin
				tile_t_d = tts_pkg::LOOKUP_W'(y_coord >> 2);
				pix_s_d = {1'b0, x_coord[1:0]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		lin_s1 <= LIN_W'(y_coord) * LIN_W'(w_eff_q) + LIN_W'(x_coord);
		lut_s1 <= tts_pkg::LUT_W'(lut_full);
		tile_t_s1 <= tile_t_d;
		pix_s_s1 <= pix_s_d;
		y_s1 <= y_coord[tts_pkg::LOOKUP_W-1:0];
		mode_s1 <= mode_q;
		tpr_s1 <= tiles_per_row(mode_q, w_eff_q);
	end

	// Tile number and row inside the tile come from the linear number by shifts.
	logic [LIN_W-1:0] tile_num;
	logic [tts_pkg::ROW_W-1:0] row_in_tile;

	always_comb begin
		case (mode_s1)
			tts_pkg::TILE_8X8: begin
				tile_num = lin_s1 >> 6;
				row_in_tile = lin_s1[5:3];
			end
			tts_pkg::TILE_8X4: begin
				tile_num = lin_s1 >> 5;
				row_in_tile = {1'b0, lin_s1[4:3]};
			end
			default: begin
				tile_num = lin_s1 >> 4;
				row_in_tile = {1'b0, lin_s1[3:2]};
			end
		endcase
	end

	// Remainder chain: index 0 feeds the first stage, index NUM_DIV is the result.
	logic valid_c [NUM_DIV+1];
	logic [QP_W-1:0] q_c [NUM_DIV+1];
	logic [BX_W-1:0] rem_c [NUM_DIV+1];
	logic [BX_W-1:0] div_c [NUM_DIV+1];
	tts_pkg::side_t side_c [NUM_DIV+1];

	assign valid_c[0] = valid_s1;
	assign q_c[0] = QP_W'(tile_num[Q_W-1:0]);
	assign rem_c[0] = '0;
	assign div_c[0] = tpr_s1;
	assign side_c[0].lut_index = lut_s1;
	assign side_c[0].tile_t = tile_t_s1;
	assign side_c[0].pix_s = pix_s_s1;
	assign side_c[0].pix_t = tts_pkg::LOOKUP_W'(row_in_tile) - y_s1 + tts_pkg::PIX_T_BIAS;

	for (genvar g = 0; g < NUM_DIV; g++) begin : g_rem
		tts_rem_stage #(
			.QP_W(QP_W),
			.STEPS(STEPS),
			.R_W(BX_W)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.valid_in(valid_c[g]),
			.q_in(q_c[g]),
			.rem_in(rem_c[g]),
			.div_in(div_c[g]),
			.side_in(side_c[g]),
			.valid_s(valid_c[g+1]),
			.q_s(q_c[g+1]),
			.rem_s(rem_c[g+1]),
			.div_s(div_c[g+1]),
			.side_s(side_c[g+1])
		);
	end

	assign done = valid_c[NUM_DIV];
	assign lut_index = side_c[NUM_DIV].lut_index;
	assign tile_s = tts_pkg::LOOKUP_W'(rem_c[NUM_DIV]);
	assign tile_t = side_c[NUM_DIV].tile_t;
	assign pix_s = side_c[NUM_DIV].pix_s;
	assign pix_t = side_c[NUM_DIV].pix_t;

	// Every accepted transaction comes out after the fixed latency, and nothing else does.
	`ASSERT_IMP(a_start_gives_done, start && !busy, ##LAT done, "result missing after start")
	`ASSERT_IMP(a_done_from_start, done, $past(start && !busy, LAT), "result without a start")
	// The remainder chain must end below its divisor with every dividend bit consumed.
	`ASSERT_IMP(a_rem_below_div, done, (rem_c[NUM_DIV] < div_c[NUM_DIV]) && (q_c[NUM_DIV] == '0),
		"tile column remainder out of range")
	// Side-band fields must stay aligned with the transaction that made them.
	`ASSERT_IMP(a_side_aligned, done,
		(lut_index[1:0] == $past(x_coord[1:0], LAT)) && (pix_s[1:0] == $past(x_coord[1:0], LAT)),
		"result fields out of step with their coordinate")

endmodule
